// ===== rtl/lmfs_pkg.sv =====
// shared types, constants and the control program of the led matrix frame store scanner
package lmfs_pkg;

    // frame store geometry
    localparam int STORE_DEPTH      = 32;
    localparam int STORE_AW         = 5;
    localparam int STORE_DW         = 8;
    localparam int ROWS_PER_DISPLAY = 7;
    localparam int PIXEL_ROWS       = 14;
    localparam int LOWER_BASE       = 16;
    localparam int RIGHT_BASE       = 8;
    localparam int DISPLAY_STRIDE   = 3;

    // register reset value
    localparam logic [7:0] LIMIT_RESET = 8'd60;

    // select base patterns
    localparam logic [7:0] SEL_ALL_OFF  = 8'hff;
    localparam logic [7:0] DIGIT_FIRST  = 8'd4;
    localparam logic [7:0] COLUMN_FIRST = 8'd1;

    // step counter of the control program
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_IDLE     = 3'd0;
    localparam t_step S_TICK     = 3'd1;
    localparam t_step S_SCAN_RD  = 3'd2;
    localparam t_step S_SCAN_OUT = 3'd3;
    localparam t_step S_PIX_RD   = 3'd4;
    localparam t_step S_PIX_WR   = 3'd5;
    localparam t_step S_COL_WR   = 3'd6;

    // command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_COLUMN = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // store read source
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_PIXEL = 2'd1,
        RD_SCAN  = 2'd2
    } t_rd;

    // store write source
    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_PIXEL  = 2'd1,
        WR_COLUMN = 2'd2
    } t_wr;

    // sequencing of the step counter
    typedef enum logic [1:0] {
        J_NEXT     = 2'd0,
        J_GOTO     = 2'd1,
        J_DISPATCH = 2'd2,
        J_LOOP     = 2'd3
    } t_jump;

    // one control word
    typedef struct packed {
        logic  in_ready;
        logic  div_step;
        logic  scan_init;
        t_rd   rd;
        t_wr   wr;
        logic  out_load;
        t_jump jump;
        t_step target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic out_busy;
        logic scan_last;
    } t_dstat;

    // control program
    function automatic t_uword urom(input t_step step);
        t_uword w;
        w = '0;
        w.rd     = RD_NONE;
        w.wr     = WR_NONE;
        w.jump   = J_GOTO;
        w.target = S_IDLE;
        case (step)
            S_IDLE: begin
                w.in_ready = 1'b1;
                w.jump     = J_DISPATCH;
            end
            S_TICK: begin
                w.div_step  = 1'b1;
                w.scan_init = 1'b1;
                w.jump      = J_NEXT;
            end
            S_SCAN_RD: begin
                w.rd   = RD_SCAN;
                w.jump = J_NEXT;
            end
            S_SCAN_OUT: begin
                w.out_load = 1'b1;
                w.jump     = J_LOOP;
                w.target   = S_SCAN_RD;
            end
            S_PIX_RD: begin
                w.rd   = RD_PIXEL;
                w.jump = J_NEXT;
            end
            S_PIX_WR: begin
                w.wr = WR_PIXEL;
            end
            S_COL_WR: begin
                w.wr = WR_COLUMN;
            end
            default: begin
                w.jump   = J_GOTO;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    // entry step of each command
    function automatic t_step cmd_entry(input t_cmd cmd);
        t_step s;
        case (cmd)
            CMD_TICK:   s = S_TICK;
            CMD_PIXEL:  s = S_PIX_RD;
            CMD_COLUMN: s = S_COL_WR;
            default:    s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/lmfs_ram.sv =====
// generic single write port ram with registered read
module lmfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lmfs_useq.sv =====
// step counter and control store of the scanner sequencer
module lmfs_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  lmfs_pkg::t_cmd  i_cmd,
    input  lmfs_pkg::t_dstat i_stat,
    output lmfs_pkg::t_uword o_uw
);

    import lmfs_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w;
    logic   hold;

    // current control word
    assign w    = urom(r_step);
    assign o_uw = w;

    // wait for an input transfer or for room in the output register
    assign hold = (w.in_ready && !i_accept) || (w.out_load && i_stat.out_busy);

    // next step
    always_comb begin
        n_step = r_step;
        if (!hold) begin
            case (w.jump)
                J_NEXT:     n_step = r_step + t_step'(1);
                J_GOTO:     n_step = w.target;
                J_DISPATCH: n_step = cmd_entry(i_cmd);
                J_LOOP:     n_step = i_stat.scan_last ? S_IDLE : w.target;
                default:    n_step = S_IDLE;
            endcase
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== rtl/lmfs_dpath.sv =====
// frame store, divider, scan position and output register of the scanner
module lmfs_dpath #(
    parameter int NUM_DISPLAYS        = 4,
    parameter int COLUMNS_PER_DISPLAY = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lmfs_pkg::t_uword i_uw,
    input  logic             i_accept,
    input  logic [3:0]       i_pixel_x,
    input  logic [3:0]       i_pixel_y,
    input  logic             i_pixel_on,
    input  logic [4:0]       i_column_address,
    input  logic [7:0]       i_column_bits,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_row_bits,
    output logic [7:0]       o_digit_select_n,
    output logic [7:0]       o_column_select_n,
    output logic             o_timing_event,
    output logic             o_last_of_scan,
    output lmfs_pkg::t_dstat o_stat
);

    import lmfs_pkg::*;

    localparam int TOTAL    = NUM_DISPLAYS * COLUMNS_PER_DISPLAY;
    localparam int PIX_COLS = 2 * COLUMNS_PER_DISPLAY;
    localparam int DW       = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;
    localparam int CW       = (COLUMNS_PER_DISPLAY > 1) ? $clog2(COLUMNS_PER_DISPLAY) : 1;
    localparam int IW       = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam logic [DW-1:0] DISP_MAX = DW'(NUM_DISPLAYS - 1);
    localparam logic [CW-1:0] COL_MAX  = CW'(COLUMNS_PER_DISPLAY - 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(TOTAL - 1);

    // pixel decode
    logic                pix_lower;
    logic                pix_ok;
    logic [3:0]          pix_y_mod;
    logic [2:0]          pix_bit;
    logic [STORE_AW-1:0] pix_col_off;
    logic [STORE_AW-1:0] pix_addr;

    // latched command fields
    logic [STORE_AW-1:0] r_pix_addr;
    logic [STORE_DW-1:0] r_pix_mask;
    logic                r_pix_on;
    logic                r_pix_ok;
    logic [STORE_AW-1:0] r_col_addr;
    logic [STORE_DW-1:0] r_col_bits;

    // divider
    logic [7:0] r_limit;
    logic [7:0] r_div;
    logic       r_wrap;

    // scan position
    logic [DW-1:0]       r_disp;
    logic [CW-1:0]       r_col;
    logic [IW-1:0]       r_idx;
    logic [DW-1:0]       adv_disp;
    logic [CW-1:0]       adv_col;
    logic [STORE_AW-1:0] scan_addr;

    // store access
    logic                   ram_rd_en;
    logic [STORE_AW-1:0]    ram_rd_addr;
    logic [STORE_DW-1:0]    ram_q;
    logic                   ram_wr_en;
    logic [STORE_AW-1:0]    ram_wr_addr;
    logic [STORE_DW-1:0]    ram_wr_data;
    logic [STORE_DEPTH-1:0] r_valid;
    logic                   r_rd_valid;
    logic [STORE_DW-1:0]    rd_q;

    // output register
    logic       load_ok;
    logic       r_out_valid;
    logic [7:0] r_row;
    logic [7:0] r_dsel;
    logic [7:0] r_csel;
    logic       r_tev;
    logic       r_last;

    // pixel to store byte and bit
    always_comb begin
        pix_lower = (i_pixel_y >= 4'(ROWS_PER_DISPLAY));
        pix_ok    = ({1'b0, i_pixel_x} < 5'(PIX_COLS)) && (i_pixel_y < 4'(PIXEL_ROWS));
        pix_y_mod = pix_lower ? (i_pixel_y - 4'(ROWS_PER_DISPLAY)) : i_pixel_y;
        pix_bit   = 3'(ROWS_PER_DISPLAY - 1) - pix_y_mod[2:0];
        if ({1'b0, i_pixel_x} < 5'(COLUMNS_PER_DISPLAY)) begin
            pix_col_off = STORE_AW'(i_pixel_x);
        end else begin
            pix_col_off = STORE_AW'(RIGHT_BASE) + STORE_AW'(i_pixel_x)
                        - STORE_AW'(COLUMNS_PER_DISPLAY);
        end
        pix_addr = (pix_lower ? STORE_AW'(LOWER_BASE) : '0) + pix_col_off;
    end

    // capture command fields on transfer
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pix_addr <= pix_addr;
            r_pix_mask <= COLUMN_FIRST << pix_bit;
            r_pix_on   <= i_pixel_on;
            r_pix_ok   <= pix_ok;
            r_col_addr <= i_column_address;
            r_col_bits <= i_column_bits;
        end
    end

    // divide limit register and tick divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_div   <= '0;
            r_wrap  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_uw.div_step) begin
                if (r_div < r_limit) begin
                    r_div  <= r_div + 8'd1;
                    r_wrap <= 1'b0;
                end else begin
                    r_div  <= '0;
                    r_wrap <= 1'b1;
                end
            end
        end
    end

    // next scan position
    always_comb begin
        if (r_col != COL_MAX) begin
            adv_col  = r_col + CW'(1);
            adv_disp = r_disp;
        end else begin
            adv_col  = '0;
            adv_disp = (r_disp != DISP_MAX) ? r_disp + DW'(1) : '0;
        end
        scan_addr = STORE_AW'(adv_col) | (STORE_AW'(adv_disp) << DISPLAY_STRIDE);
    end

    // scan position and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp <= '0;
            r_col  <= '0;
            r_idx  <= '0;
        end else begin
            if (i_uw.scan_init) begin
                r_disp <= '0;
                r_col  <= '0;
                r_idx  <= '0;
            end else begin
                if (i_uw.rd == RD_SCAN) begin
                    r_disp <= adv_disp;
                    r_col  <= adv_col;
                end
                if (load_ok) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
        end
    end

    // store port control
    always_comb begin
        ram_rd_en   = (i_uw.rd != RD_NONE);
        ram_rd_addr = (i_uw.rd == RD_SCAN) ? scan_addr : r_pix_addr;
        rd_q        = r_rd_valid ? ram_q : '0;
        ram_wr_en   = ((i_uw.wr == WR_PIXEL) && r_pix_ok) || (i_uw.wr == WR_COLUMN);
        ram_wr_addr = (i_uw.wr == WR_COLUMN) ? r_col_addr : r_pix_addr;
        if (i_uw.wr == WR_COLUMN) begin
            ram_wr_data = r_col_bits;
        end else if (r_pix_on) begin
            ram_wr_data = rd_q | r_pix_mask;
        end else begin
            ram_wr_data = rd_q & ~r_pix_mask;
        end
    end

    // written flags, an unwritten byte reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (ram_wr_en) begin
                r_valid[ram_wr_addr] <= 1'b1;
            end
            if (ram_rd_en) begin
                r_rd_valid <= r_valid[ram_rd_addr];
            end
        end
    end

    lmfs_ram #(
        .WIDTH(STORE_DW),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    // output register
    assign load_ok = i_uw.out_load && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_row  <= rd_q;
            r_dsel <= SEL_ALL_OFF - (DIGIT_FIRST << r_disp);
            r_csel <= SEL_ALL_OFF - (COLUMN_FIRST << r_col);
            r_tev  <= r_wrap && (r_idx == '0);
            r_last <= (r_idx == IDX_LAST);
        end
    end

    // status toward the sequencer
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;
    assign o_stat.scan_last = (r_idx == IDX_LAST);

    assign o_out_valid       = r_out_valid;
    assign o_row_bits        = r_row;
    assign o_digit_select_n  = r_dsel;
    assign o_column_select_n = r_csel;
    assign o_timing_event    = r_tev;
    assign o_last_of_scan    = r_last;

endmodule

// ===== rtl/led_matrix_frame_store_scanner.sv =====
// top level of the led matrix frame store scanner
//
// Keeps a 32-byte column store (cleared at reset through per-byte written flags, so there is
// no clearing pass and the block takes items right out of reset) for up to four 5x7 displays
// set two over two. Input tuser carries the command: a tick steps the divider and then
// emits NUM_DISPLAYS * COLUMNS_PER_DISPLAY scan transfers, starting at display 0 column 1
// and ending at display 0 column 0, with tlast on the final one and tuser high on the first
// one when the divider wrapped; a pixel write and a column write emit nothing. A tick runs
// the divider step and then a read step and an output step for each scan column, a pixel
// write reads and rewrites its byte, a column write writes its byte, an unused command is dropped.
// Each scan column costs two control steps because the store has one read port with a
// registered output, and the sequencer runs one item at a time; a stalled output holds
// the scan. The divide limit may be written whenever no command is in progress.
module led_matrix_frame_store_scanner #(
    parameter int NUM_DISPLAYS        = 4,
    parameter int COLUMNS_PER_DISPLAY = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pixel_x[3:0], pixel_y[7:4], pixel_on[8],
                                       // column_address[13:9], column_bits[21:14], zero
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata, // row_bits[7:0], digit_select_n[15:8],
                                       // column_select_n[23:16]
    output logic        m_axis_tuser,  // timing_event
    output logic        m_axis_tlast,  // last_of_scan
    // divide limit register
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    import lmfs_pkg::*;

    t_uword     uw;
    t_dstat     stat;
    logic       accept;
    logic [7:0] row_bits;
    logic [7:0] digit_select_n;
    logic [7:0] column_select_n;

    // input transfer, held off while in reset
    assign s_axis_tready = uw.in_ready && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // sequencer
    lmfs_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (t_cmd'(s_axis_tuser)),
        .i_stat   (stat),
        .o_uw     (uw)
    );

    // datapath
    lmfs_dpath #(
        .NUM_DISPLAYS        (NUM_DISPLAYS),
        .COLUMNS_PER_DISPLAY (COLUMNS_PER_DISPLAY)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_uw              (uw),
        .i_accept          (accept),
        .i_pixel_x         (s_axis_tdata[3:0]),
        .i_pixel_y         (s_axis_tdata[7:4]),
        .i_pixel_on        (s_axis_tdata[8]),
        .i_column_address  (s_axis_tdata[13:9]),
        .i_column_bits     (s_axis_tdata[21:14]),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_row_bits        (row_bits),
        .o_digit_select_n  (digit_select_n),
        .o_column_select_n (column_select_n),
        .o_timing_event    (m_axis_tuser),
        .o_last_of_scan    (m_axis_tlast),
        .o_stat            (stat)
    );

    // result packing
    assign m_axis_tdata = {column_select_n, digit_select_n, row_bits};

endmodule

// ===== rtl/lmfs_checker.sv =====
// port-level checks of the led matrix frame store scanner and their binding
module lmfs_checker #(
    parameter int NUM_DISPLAYS        = 4,
    parameter int COLUMNS_PER_DISPLAY = 5
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    import lmfs_pkg::*;

    localparam int TOTAL = NUM_DISPLAYS * COLUMNS_PER_DISPLAY;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a tick transfer starts a scan, so input is held off next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TICK) |=> !s_axis_tready)
        else $error("input taken during scan");

    // exactly one display and one column selected
    a_one_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(~m_axis_tdata[15:8]) == 1)
                       && ($countones(~m_axis_tdata[23:16]) == 1))
        else $error("select lines not one-cold");

    // timing flag never on the last result of a scan longer than one column
    a_event_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TOTAL > 1) && m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
        else $error("timing flag on last result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind led_matrix_frame_store_scanner lmfs_checker #(
    .NUM_DISPLAYS        (NUM_DISPLAYS),
    .COLUMNS_PER_DISPLAY (COLUMNS_PER_DISPLAY)
) u_lmfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/lmfs_scan_checker.sv =====
// scoreboard that predicts and checks the scan transfers of the led matrix frame store scanner
`timescale 1ns / 1ps

module lmfs_scan_checker #(
    parameter int NUM_DISPLAYS        = 4,
    parameter int COLUMNS_PER_DISPLAY = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    import lmfs_pkg::*;

    localparam int MAX_REPORTS = 10;

    // one scanned column as it should appear on the result stream
    typedef struct packed {
        logic [7:0] row_bits;
        logic [7:0] digit_sel_n;
        logic [7:0] column_sel_n;
        logic       timing_event;
        logic       last_of_scan;
    } t_scan;

    logic [7:0] frame_q [STORE_DEPTH];
    logic [7:0] divider_q;
    logic [7:0] limit_q;
    t_scan      scan_expect_q [$];
    int         fails;
    int         checked;

    // set or clear one image pixel, off-image coordinates change nothing
    task automatic paint_pixel(input logic [3:0] x, input logic [3:0] y, input logic on);
        int         addr;
        int         row_bit;
        logic [7:0] mask;
        if (int'(x) >= 2 * COLUMNS_PER_DISPLAY || int'(y) >= PIXEL_ROWS) return;
        addr = (int'(y) < ROWS_PER_DISPLAY) ? 0 : LOWER_BASE;
        if (int'(x) < COLUMNS_PER_DISPLAY)
            addr += int'(x);
        else
            addr += RIGHT_BASE + int'(x) - COLUMNS_PER_DISPLAY;
        addr    = addr % STORE_DEPTH;
        row_bit = (ROWS_PER_DISPLAY - 1) - (int'(y) % ROWS_PER_DISPLAY);
        mask    = 8'd1 << row_bit;
        if (on)
            frame_q[addr] = frame_q[addr] | mask;
        else
            frame_q[addr] = frame_q[addr] & ~mask;
    endtask

    // step the divider, then queue one transfer per display column in scan order
    task automatic queue_scan();
        logic  wrapped;
        int    display;
        int    column;
        int    total;
        t_scan s;
        wrapped = 1'b0;
        display = 0;
        column  = 0;
        total   = NUM_DISPLAYS * COLUMNS_PER_DISPLAY;
        if (divider_q < limit_q) begin
            divider_q = divider_q + 8'd1;
        end else begin
            divider_q = '0;
            wrapped   = 1'b1;
        end
        for (int i = 0; i < total; i++) begin
            if (column + 1 < COLUMNS_PER_DISPLAY) begin
                column++;
            end else begin
                display = (display + 1 < NUM_DISPLAYS) ? display + 1 : 0;
                column  = 0;
            end
            s.row_bits     = frame_q[(column + (display << DISPLAY_STRIDE)) % STORE_DEPTH];
            s.digit_sel_n  = SEL_ALL_OFF - (DIGIT_FIRST << display);
            s.column_sel_n = SEL_ALL_OFF - (COLUMN_FIRST << column);
            s.timing_event = (i == 0) && wrapped;
            s.last_of_scan = (i + 1 == total);
            scan_expect_q.push_back(s);
        end
    endtask

    // watch both streams and the register port on every rising edge
    always @(posedge i_clk) begin
        t_scan got;
        t_scan want;
        t_cmd  cmd;
        if (!i_rst_n) begin
            foreach (frame_q[a]) frame_q[a] = '0;
            divider_q = '0;
            limit_q   = LIMIT_RESET;
            scan_expect_q.delete();
        end else begin
            if (i_cfg_we) limit_q = i_cfg_wdata;

            // result transfer against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.row_bits     = m_axis_tdata[7:0];
                got.digit_sel_n  = m_axis_tdata[15:8];
                got.column_sel_n = m_axis_tdata[23:16];
                got.timing_event = m_axis_tuser;
                got.last_of_scan = m_axis_tlast;
                checked++;
                if (scan_expect_q.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: unexpected row=%02h dig=%02h col=%02h ev=%b last=%b",
                                 $realtime, got.row_bits, got.digit_sel_n, got.column_sel_n,
                                 got.timing_event, got.last_of_scan);
                    fails++;
                end else begin
                    want = scan_expect_q.pop_front();
                    if (got !== want) begin
                        if (fails < MAX_REPORTS) begin
                            $write("%0t: mismatch exp row=%02h dig=%02h col=%02h ev=%b last=%b",
                                   $realtime, want.row_bits, want.digit_sel_n,
                                   want.column_sel_n, want.timing_event, want.last_of_scan);
                            $display(" got row=%02h dig=%02h col=%02h ev=%b last=%b",
                                     got.row_bits, got.digit_sel_n, got.column_sel_n,
                                     got.timing_event, got.last_of_scan);
                        end
                        fails++;
                    end
                end
            end

            // command transfer updates the store or queues a scan
            if (s_axis_tvalid && s_axis_tready) begin
                cmd = t_cmd'(s_axis_tuser);
                case (cmd)
                    CMD_TICK:   queue_scan();
                    CMD_PIXEL:  paint_pixel(s_axis_tdata[3:0], s_axis_tdata[7:4], s_axis_tdata[8]);
                    CMD_COLUMN: frame_q[s_axis_tdata[13:9]] = s_axis_tdata[21:14];
                    default: ;
                endcase
            end
        end
        o_fail_count = fails;
        o_pending    = scan_expect_q.size();
        o_checked    = checked;
    end

endmodule

// ===== tb/tb_led_matrix_frame_store_scanner.sv =====
// top of the led matrix frame store scanner testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_led_matrix_frame_store_scanner;
    import lmfs_pkg::*;

    localparam int NUM_DISPLAYS        = 4;
    localparam int COLUMNS_PER_DISPLAY = 5;
    localparam int SETTLE_CYCLES       = 60;
    localparam int HOLD_CYCLES         = 400;
    localparam int IDLE_PCT            = 8;
    localparam int TIMEOUT_NS          = 1_000_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = CMD_NOP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = '0;

    int fail_count;
    int pending;
    int checked;

    // stimulus bookkeeping
    int   items_sent;
    int   ticks_sent;
    logic quiet_run;
    int   hold_req;
    int   hold_seen;
    int   hold_left;
    string limit_log;

    always #1 i_clk = ~i_clk;

    led_matrix_frame_store_scanner #(
        .NUM_DISPLAYS        (NUM_DISPLAYS),
        .COLUMNS_PER_DISPLAY (COLUMNS_PER_DISPLAY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    lmfs_scan_checker #(
        .NUM_DISPLAYS        (NUM_DISPLAYS),
        .COLUMNS_PER_DISPLAY (COLUMNS_PER_DISPLAY)
    ) u_scan_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // result side: random stalls, quiet stretches and a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (quiet_run) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // pack the command fields the way the block expects them
    function automatic logic [23:0] pack_fields(input logic [3:0] x, input logic [3:0] y,
                                                input logic on, input logic [4:0] addr,
                                                input logic [7:0] bits);
        return {2'b00, bits, addr, on, y, x};
    endfunction

    // offer one command and hold it until the block takes it
    task automatic send_command(input t_cmd cmd, input logic [23:0] fields);
        logic took;
        while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= fields;
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
        if (cmd == CMD_TICK) ticks_sent++;
    endtask

    // stop offering and let every expected scan drain, then allow the block to settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the divide limit while nothing is in flight
    task automatic set_limit(input logic [7:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_log = $sformatf("%s %0d", limit_log, value);
    endtask

    // random commands, pixels mostly in-image, with unused fields filled at random
    task automatic run_random(input int count, input int tick_pct, input int hold_at);
        int          done;
        int          pick;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [23:0] fields;
        t_cmd        cmd;
        done = 0;
        while (done < count) begin
            if (done == hold_at) hold_req++;
            x = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                             : 4'($urandom_range(10, 15));
            y = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 13))
                                             : 4'($urandom_range(14, 15));
            fields = pack_fields(x, y, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                                 8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < tick_pct)
                cmd = CMD_TICK;
            else if (pick < 6)
                cmd = CMD_NOP;
            else if (pick < 60)
                cmd = CMD_PIXEL;
            else
                cmd = CMD_COLUMN;
            send_command(cmd, fields);
            if (cmd != CMD_NOP) done++;
        end
    endtask

    initial begin
        items_sent = 0;
        ticks_sent = 0;
        quiet_run  = 1'b0;
        hold_req   = 0;
        limit_log  = " 60";

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store scan, image corners and edges, raw bytes, ignored pixels
        send_command(CMD_TICK,   pack_fields(4'd0, 4'd0, 1'b0, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd0, 4'd0, 1'b1, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd9, 4'd13, 1'b1, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd4, 4'd6, 1'b1, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd5, 4'd7, 1'b1, 5'd0, 8'h00));
        send_command(CMD_COLUMN, pack_fields(4'd0, 4'd0, 1'b0, 5'd31, 8'hff));
        send_command(CMD_COLUMN, pack_fields(4'd0, 4'd0, 1'b0, 5'd0, 8'h80));
        send_command(CMD_PIXEL,  pack_fields(4'd0, 4'd0, 1'b1, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd10, 4'd3, 1'b1, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd15, 4'd15, 1'b1, 5'd31, 8'hff));
        send_command(CMD_PIXEL,  pack_fields(4'd3, 4'd14, 1'b1, 5'd0, 8'h00));
        send_command(CMD_NOP,    pack_fields(4'd15, 4'd15, 1'b1, 5'd31, 8'hff));
        send_command(CMD_TICK,   pack_fields(4'd15, 4'd15, 1'b1, 5'd31, 8'hff));
        send_command(CMD_PIXEL,  pack_fields(4'd0, 4'd0, 1'b0, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd9, 4'd13, 1'b0, 5'd0, 8'h00));
        send_command(CMD_COLUMN, pack_fields(4'd0, 4'd0, 1'b0, 5'd12, 8'h55));
        send_command(CMD_COLUMN, pack_fields(4'd0, 4'd0, 1'b0, 5'd19, 8'haa));
        send_command(CMD_COLUMN, pack_fields(4'd0, 4'd0, 1'b0, 5'd28, 8'h7f));
        send_command(CMD_TICK,   pack_fields(4'd0, 4'd0, 1'b0, 5'd0, 8'h00));
        send_command(CMD_PIXEL,  pack_fields(4'd7, 4'd10, 1'b1, 5'd0, 8'h00));
        send_command(CMD_COLUMN, pack_fields(4'd0, 4'd0, 1'b0, 5'd0, 8'h00));
        send_command(CMD_TICK,   pack_fields(4'd0, 4'd0, 1'b0, 5'd0, 8'h00));

        // limit zero wraps on every tick
        set_limit(8'd0);
        run_random(80, 40, -1);

        // widest limit, with the result side held off for a long stretch
        set_limit(8'd255);
        run_random(80, 40, 20);

        // small limit, with neither side idling
        set_limit(8'd3);
        quiet_run = 1'b1;
        run_random(80, 50, -1);
        quiet_run = 1'b0;

        set_limit(8'($urandom_range(0, 255)));
        run_random(80, 40, -1);

        // back to the reset value, tick heavy so the divider wraps
        set_limit(LIMIT_RESET);
        run_random(90, 80, -1);

        wait_drained();
        $display("covered %0d commands, %0d of them ticks, divide limits:%s",
                 items_sent, ticks_sent, limit_log);
        $display("compared %0d scan transfers, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d scan transfers outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
